// File: sv/cms_pkg.sv
// Shared constants and types for the scaled cumulative mean block.
package cms_pkg;

  // Sample bits that take part in the average; the rest of the port is ignored.
  localparam int unsigned SAMPLE_BITS = 32;
  // Width of the saturating sample counter.
  localparam int unsigned COUNT_BITS  = 32;
  // Width of the scaled mean and of the difference fed to the divider.
  localparam int unsigned MEAN_W      = 64;
  // Divisor width: the count plus one can reach two to the COUNT_BITS.
  localparam int unsigned DIV_W       = COUNT_BITS + 1;
  // One divider step per dividend bit.
  localparam int unsigned STEP_W      = $clog2(MEAN_W);
  // Width of the scale shift register.
  localparam int unsigned SHIFT_W     = 5;

  // Input action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef logic [MEAN_W-1:0] mean_t;
  typedef logic [DIV_W-1:0]  divisor_t;

endpackage

// File: sv/cms_divider.sv
// Iterative radix-2 restoring divider: unsigned dividend by unsigned divisor.
module cms_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  cms_pkg::mean_t     dividend_i,
  input  cms_pkg::divisor_t  divisor_i,
  output logic               done_o,
  output cms_pkg::mean_t     quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cms_pkg::STEP_W-1:0]    step_q, step_d;
  cms_pkg::divisor_t             rem_q, rem_d;
  cms_pkg::divisor_t             dsr_q, dsr_d;
  cms_pkg::mean_t                quo_q, quo_d;

  logic [cms_pkg::DIV_W:0]       shifted;
  logic [cms_pkg::DIV_W:0]       trial;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[cms_pkg::MEAN_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!trial[cms_pkg::DIV_W]) begin
        rem_d = trial[cms_pkg::DIV_W-1:0];
      end else begin
        rem_d = shifted[cms_pkg::DIV_W-1:0];
      end
      quo_d  = {quo_q[cms_pkg::MEAN_W-2:0], ~trial[cms_pkg::DIV_W]};
      step_d = step_q + 1'b1;
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/cumulative_mean_scaled.sv
// Top level of the scaled cumulative mean block: sequencer, state and output register.
//
// Each sample is sign-extended, shifted left by scale_shift into 64 bits and folded
// into a running mean: the first sample after a clear becomes the mean, and each
// later one adds (scaled - mean) / (count + 1), truncated toward zero. The divide
// runs on a single radix-2 divider at one quotient bit per cycle. A sample that
// needs it is busy from acceptance until its result is loaded into the output
// register, passing through ST_PREP to start the divider, ST_DIV for the divider
// steps, the done flag and the sign, ST_APPLY to add and ST_FINISH to load the
// output register. The difference is formed at the accepting edge. The input is
// ready again in the cycle after the load, so the next sample is not accepted before
// this one is loaded. The first sample after a clear goes straight to ST_FINISH, so
// the next item can follow its load, and a clear item can be followed in the next
// cycle. A result still waiting in the output register holds the next result back,
// and the input stays not ready until that one is loaded. The input becomes ready
// as soon as the result sits in the output register, even if it is not yet taken.
// The sample count saturates at its maximum. Each sample gives one result, a
// clear gives none. scale_shift may only be written while the block is idle.
module cumulative_mean_scaled (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cms_pkg::SHIFT_W-1:0]        cfg_scale_shift_i,
  // Input item channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic signed [31:0]                 sample_i,
  // Result item channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [63:0]                 mean_o,
  output logic [31:0]                        sample_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_e;

  state_e                             state_q, state_d;
  logic [cms_pkg::SHIFT_W-1:0]        shift_q, shift_d;
  cms_pkg::mean_t                     mean_q, mean_d;
  logic [cms_pkg::COUNT_BITS-1:0]     count_q, count_d;
  cms_pkg::mean_t                     diff_q, diff_d;
  cms_pkg::divisor_t                  dsr_q, dsr_d;
  cms_pkg::mean_t                     step_q, step_d;
  logic                               out_valid_q, out_valid_d;
  cms_pkg::mean_t                     out_mean_q, out_mean_d;
  logic [cms_pkg::COUNT_BITS-1:0]     out_count_q, out_count_d;

  logic                               in_fire;
  cms_pkg::mean_t                     sample_ext;
  cms_pkg::mean_t                     scaled;
  logic                               div_start;
  cms_pkg::mean_t                     div_dividend;
  logic                               div_done;
  cms_pkg::mean_t                     div_quotient;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Sign-extend the used sample bits and apply the configured scale.
  assign sample_ext = {{(cms_pkg::MEAN_W - cms_pkg::SAMPLE_BITS)
                        {sample_i[cms_pkg::SAMPLE_BITS-1]}},
                       sample_i[cms_pkg::SAMPLE_BITS-1:0]};
  assign scaled     = sample_ext << shift_q;

  // The divider works on the magnitude of the difference.
  assign div_start    = (state_q == ST_PREP);
  assign div_dividend = diff_q[cms_pkg::MEAN_W-1] ? (~diff_q + 1'b1) : diff_q;

  cms_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (dsr_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Sequencer and state update.
  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    mean_d      = mean_q;
    count_d     = count_q;
    diff_d      = diff_q;
    dsr_d       = dsr_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_count_d = out_count_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      shift_d = cfg_scale_shift_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i == cms_pkg::ACT_CLEAR) begin
            mean_d  = '0;
            count_d = '0;
          end else begin
            if (count_q == '0) begin
              mean_d  = scaled;
              state_d = ST_FINISH;
            end else begin
              diff_d  = scaled - mean_q;
              dsr_d   = {1'b0, count_q} + 1'b1;
              state_d = ST_PREP;
            end
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      ST_PREP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Restore the sign of the truncated quotient.
        if (div_done) begin
          step_d  = diff_q[cms_pkg::MEAN_W-1] ? (~div_quotient + 1'b1) : div_quotient;
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        mean_d  = mean_q + step_q;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mean_d  = mean_q;
          out_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= '0;
      mean_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_q     <= shift_d;
      mean_q      <= mean_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q      <= diff_d;
    dsr_q       <= dsr_d;
    step_q      <= step_d;
    out_mean_q  <= out_mean_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign mean_o         = out_mean_q;
  assign sample_count_o = 32'(out_count_q);

  // A clear item leaves the count at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == cms_pkg::ACT_CLEAR) |=> count_q == '0)
    else $error("count not cleared by a clear item");

  // Every result reports at least one averaged sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0)
    else $error("result with a zero sample count");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  // The first sample after a clear becomes the mean as it is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == cms_pkg::ACT_SAMPLE) && (count_q == '0)
    |=> mean_q == $past(scaled))
    else $error("first sample did not become the mean");

endmodule

// File: bench/tb_cumulative_mean_scaled.sv
// Self-checking testbench for the scaled cumulative mean block.
`timescale 1ns / 100ps

module tb_cumulative_mean_scaled;

  // Cycles to let the block settle after the last result.
  localparam int unsigned SETTLE_CYCLES = 80;
  // Watchdog limit, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Number of mismatches that are reported in full.
  localparam int unsigned REPORT_LIMIT  = 10;

  // One result item as the block should deliver it.
  typedef struct packed {
    logic signed [63:0] mean;
    logic [31:0]        count;
  } avg_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [cms_pkg::SHIFT_W-1:0]         cfg_scale_shift_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                action_i;
  logic signed [31:0]                  sample_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [63:0]                  mean_o;
  logic [31:0]                         sample_count_o;

  // Predicted state of the averager.
  logic signed [63:0]                  avg_mean;
  longint unsigned                     avg_count;
  logic [cms_pkg::SHIFT_W-1:0]         avg_shift;

  avg_result_t                         pending_means[$];
  int unsigned                         mismatch_count;
  int unsigned                         cycle_count;
  int unsigned                         send_idle_pct;
  int unsigned                         recv_stall_pct;

  cumulative_mean_scaled dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_scale_shift_i (cfg_scale_shift_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mean_o            (mean_o),
    .sample_count_o    (sample_count_o)
  );

  // Clock with an 8 ns period, starting low.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Record a failure; only the first few are printed in full.
  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Fold one accepted item into the predicted state and, for a sample, queue its result.
  function automatic void fold_sample(input logic act, input logic signed [31:0] smp);
    longint      reading;
    longint      scaled;
    longint      divisor;
    longint      count_max;
    avg_result_t res;
    count_max = (longint'(1) << cms_pkg::COUNT_BITS) - 1;
    if (act == cms_pkg::ACT_CLEAR) begin
      avg_mean  = '0;
      avg_count = 0;
    end else begin
      // Sign-extend from the used sample bits, then scale in 64 bits.
      reading = (longint'(smp) <<< (64 - cms_pkg::SAMPLE_BITS))
                >>> (64 - cms_pkg::SAMPLE_BITS);
      scaled  = reading <<< avg_shift;
      if (avg_count != 0) begin
        divisor  = longint'(avg_count) + 1;
        avg_mean = avg_mean + (scaled - avg_mean) / divisor;
      end else begin
        avg_mean = scaled;
      end
      if (avg_count < count_max) begin
        avg_count++;
      end
      res.mean  = avg_mean;
      res.count = avg_count[31:0];
      pending_means.push_back(res);
    end
  endfunction

  // Send one input item, with random idle cycles ahead of it.
  task automatic send_item(input logic act, input logic signed [31:0] smp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    sample_i   = smp;
    do @(posedge clk_i); while (!in_ready_o);
    fold_sample(act, smp);
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the scale shift register once the block is idle.
  task automatic write_shift(input logic [cms_pkg::SHIFT_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i       = 1'b1;
    cfg_scale_shift_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    avg_shift = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Pick a reading: extremes, small values, powers of two and full-range random words.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4:       return $signed($urandom_range(200)) - 32'sd100;
      5:       return $signed(32'd1 << $urandom_range(31));
      default: return $signed($urandom());
    endcase
  endfunction

  // Default scale after reset, truncation toward zero and the extreme readings.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(cms_pkg::ACT_SAMPLE, 32'sd100);
    send_item(cms_pkg::ACT_SAMPLE, -32'sd101);
    send_item(cms_pkg::ACT_SAMPLE, 32'sd7);
    send_item(cms_pkg::ACT_SAMPLE, -32'sd9);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh8000_0000);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh7fff_ffff);
    // Back-to-back clears, then the first sample after a clear.
    send_item(cms_pkg::ACT_CLEAR, 32'sh5a5a_5a5a);
    send_item(cms_pkg::ACT_CLEAR, '0);
    send_item(cms_pkg::ACT_SAMPLE, -32'sd5);
    send_item(cms_pkg::ACT_SAMPLE, '0);
    send_item(cms_pkg::ACT_SAMPLE, -32'sd1);
    send_item(cms_pkg::ACT_SAMPLE, 32'sd1);
    // Largest scale with both extremes of the reading.
    write_shift(5'd31);
    send_item(cms_pkg::ACT_CLEAR, 32'sh7fff_ffff);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh7fff_ffff);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh8000_0000);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh8000_0000);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh7fff_ffff);
    send_item(cms_pkg::ACT_SAMPLE, -32'sd1);
    send_item(cms_pkg::ACT_CLEAR, '0);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh8000_0000);
    send_item(cms_pkg::ACT_SAMPLE, 32'sh7fff_ffff);
  endtask

  // Several scale settings, each with a short run of readings.
  task automatic test_scale_sweep();
    logic [cms_pkg::SHIFT_W-1:0] shifts[6];
    shifts = '{5'd1, 5'd16, 5'd30, 5'd31, 5'd0, 5'd0};
    shifts[5] = cms_pkg::SHIFT_W'($urandom());
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    foreach (shifts[i]) begin
      write_shift(shifts[i]);
      if (i % 2 == 0) begin
        send_item(cms_pkg::ACT_CLEAR, $signed($urandom()));
      end
      repeat (6) send_item(cms_pkg::ACT_SAMPLE, pick_sample());
    end
  endtask

  // Random readings with occasional clears under one idling pattern.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_items);
    logic [cms_pkg::SHIFT_W-1:0] shift;
    case ($urandom_range(3))
      0:       shift = '0;
      1:       shift = '1;
      default: shift = cms_pkg::SHIFT_W'($urandom());
    endcase
    write_shift(shift);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      if ($urandom_range(99) < 4) begin
        send_item(cms_pkg::ACT_CLEAR, $signed($urandom()));
      end else begin
        send_item(cms_pkg::ACT_SAMPLE, pick_sample());
      end
    end
  endtask

  // Receiver: stall at random according to the current phase.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    avg_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_means.size() == 0) begin
        note_failure($sformatf("unexpected result: mean %0d count %0d",
                               mean_o, sample_count_o));
      end else begin
        want = pending_means.pop_front();
        if (mean_o !== want.mean) begin
          note_failure($sformatf("mean: expected %0d, got %0d", want.mean, mean_o));
        end
        if (sample_count_o !== want.count) begin
          note_failure($sformatf("sample_count: expected %0d, got %0d",
                                 want.count, sample_count_o));
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_scale_shift_i = '0;
    in_valid_i        = 1'b0;
    action_i          = cms_pkg::ACT_SAMPLE;
    sample_i          = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    avg_mean          = '0;
    avg_count         = 0;
    avg_shift         = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_scale_sweep();
    test_random_phase(0, 0, 225);
    test_random_phase(70, 0, 225);
    test_random_phase(0, 70, 225);
    test_random_phase(23, 23, 225);

    wait_idle();
    if (pending_means.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_means.size()));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: cumulative_mean_scaled.f
sv/cms_pkg.sv
sv/cms_divider.sv
sv/cumulative_mean_scaled.sv
bench/tb_cumulative_mean_scaled.sv
